// ----- src/ogg_pkg.sv -----
// ---------------------------------------------------------------------------
// ogg_pkg: shared types and constants for the Ogg page header parser
// Byte kinds, parse phases, header byte offsets and the result word layout.
// ---------------------------------------------------------------------------
package ogg_pkg;

  // Header is bytes 0..26; byte 26 holds the lacing count
  localparam logic [4:0] HDR_VERSION  = 5'd4;
  localparam logic [4:0] HDR_TYPE     = 5'd5;
  localparam logic [4:0] HDR_GRANULE  = 5'd6;
  localparam logic [4:0] HDR_SERIAL   = 5'd14;
  localparam logic [4:0] HDR_SEQUENCE = 5'd18;
  localparam logic [4:0] HDR_CHECKSUM = 5'd22;
  localparam logic [4:0] HDR_LAST     = 5'd26;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_LACING  = 2'd1,
    KIND_PAYLOAD = 2'd2,
    KIND_ERROR   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_LACING  = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  // One result word, as handed from the parser to the output register
  typedef struct packed {
    kind_t              byte_kind;
    logic [7:0]         payload_data;
    logic               header_valid;
    logic [7:0]         page_flags;
    logic signed [63:0] granule_position;
    logic [31:0]        stream_serial;
    logic [31:0]        page_sequence;
    logic [31:0]        page_checksum;
    logic [7:0]         lacing_count;
    logic [15:0]        payload_size;
    logic               page_end;
  } result_t;

  // Capture pattern "OggS"
  function automatic logic [7:0] capture_byte(input logic [1:0] idx);
    logic [7:0] val;
    unique case (idx)
      2'd0:    val = 8'h4F;
      2'd1:    val = 8'h67;
      2'd2:    val = 8'h67;
      default: val = 8'h53;
    endcase
    return val;
  endfunction

endpackage

// ----- src/ogg_ifs.sv -----
// ---------------------------------------------------------------------------
// ogg_ifs: stream channels of the Ogg page header parser
// Byte input channel and tagged result channel, valid/ready handshake.
// ---------------------------------------------------------------------------
interface ogg_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink   (input valid, input stream_byte, output ready);
endinterface

interface ogg_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         byte_kind;
  logic [7:0]         payload_data;
  logic               header_valid;
  logic [7:0]         page_flags;
  logic signed [63:0] granule_position;
  logic [31:0]        stream_serial;
  logic [31:0]        page_sequence;
  logic [31:0]        page_checksum;
  logic [7:0]         lacing_count;
  logic [15:0]        payload_size;
  logic               page_end;

  modport source (
    output valid, input ready,
    output byte_kind, output payload_data, output header_valid, output page_flags,
    output granule_position, output stream_serial, output page_sequence,
    output page_checksum, output lacing_count, output payload_size, output page_end
  );
  modport sink (
    input valid, output ready,
    input byte_kind, input payload_data, input header_valid, input page_flags,
    input granule_position, input stream_serial, input page_sequence,
    input page_checksum, input lacing_count, input payload_size, input page_end
  );
endinterface

// ----- src/ogg_in_stage.sv -----
// ---------------------------------------------------------------------------
// ogg_in_stage: input register
// Holds one stream word; refills in the same cycle the held word moves on.
// ---------------------------------------------------------------------------
module ogg_in_stage (
  input  logic        clk,
  input  logic        rst_n,
  ogg_in_if.sink      in_ch,
  input  logic        take,
  output logic        held_valid,
  output logic [7:0]  held_byte
);

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;
  logic       load;

  // Accept when empty or when the held word leaves this cycle
  assign in_ch.ready = !valid_r || take;
  assign load        = in_ch.valid && in_ch.ready;
  assign valid_nxt   = load ? 1'b1 : (take ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= in_ch.stream_byte;
    end
  end

  assign held_valid = valid_r;
  assign held_byte  = byte_r;

endmodule

// ----- src/ogg_parse.sv -----
// ---------------------------------------------------------------------------
// ogg_parse: page parse state and per-byte tagging
// Tracks header/lacing/payload phase, collects header fields and sizes.
// ---------------------------------------------------------------------------
module ogg_parse (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  logic [7:0]       in_byte,
  output ogg_pkg::result_t res
);

  ogg_pkg::phase_t phase_r, phase_nxt;
  logic [4:0]      idx_r, idx_nxt;
  logic            pat_r, pat_nxt;
  logic [7:0]      type_r, type_nxt;
  logic [63:0]     gran_r, gran_nxt;
  logic [31:0]     serial_r, serial_nxt;
  logic [31:0]     seq_r, seq_nxt;
  logic [31:0]     csum_r, csum_nxt;
  logic [7:0]      ltot_r, ltot_nxt;
  logic [7:0]      lleft_r, lleft_nxt;
  logic [16:0]     psum_r, psum_nxt;
  logic [16:0]     pleft_r, pleft_nxt;

  ogg_pkg::kind_t  kind;
  logic [7:0]      data;
  logic            hvalid;
  logic            pend;
  logic [4:0]      goff, soff, qoff, coff;

  // Byte offsets within the multi-byte header fields
  assign goff = idx_r - ogg_pkg::HDR_GRANULE;
  assign soff = idx_r - ogg_pkg::HDR_SERIAL;
  assign qoff = idx_r - ogg_pkg::HDR_SEQUENCE;
  assign coff = idx_r - ogg_pkg::HDR_CHECKSUM;

  // Next state and result for the current byte
  always_comb begin
    phase_nxt  = phase_r;
    idx_nxt    = idx_r;
    pat_nxt    = pat_r;
    type_nxt   = type_r;
    gran_nxt   = gran_r;
    serial_nxt = serial_r;
    seq_nxt    = seq_r;
    csum_nxt   = csum_r;
    ltot_nxt   = ltot_r;
    lleft_nxt  = lleft_r;
    psum_nxt   = psum_r;
    pleft_nxt  = pleft_r;
    kind       = ogg_pkg::KIND_HEADER;
    data       = 8'd0;
    hvalid     = 1'b0;
    pend       = 1'b0;

    unique case (phase_r)
      ogg_pkg::PH_LACING: begin
        kind      = ogg_pkg::KIND_LACING;
        psum_nxt  = psum_r + {9'd0, in_byte};
        lleft_nxt = lleft_r - 8'd1;
        if (lleft_nxt == 8'd0) begin
          if (psum_nxt == 17'd0) begin
            pend      = 1'b1;
            phase_nxt = ogg_pkg::PH_HEADER;
            idx_nxt   = 5'd0;
            pat_nxt   = 1'b1;
          end else begin
            pleft_nxt = psum_nxt;
            phase_nxt = ogg_pkg::PH_PAYLOAD;
          end
        end
      end
      ogg_pkg::PH_PAYLOAD: begin
        kind      = ogg_pkg::KIND_PAYLOAD;
        data      = in_byte;
        pleft_nxt = pleft_r - 17'd1;
        if (pleft_nxt == 17'd0) begin
          pend      = 1'b1;
          phase_nxt = ogg_pkg::PH_HEADER;
          idx_nxt   = 5'd0;
          pat_nxt   = 1'b1;
        end
      end
      default: begin
        // Header byte: check the capture pattern and version, or store the field this offset belongs to
        priority if (idx_r < ogg_pkg::HDR_VERSION) begin
          if (in_byte != ogg_pkg::capture_byte(idx_r[1:0])) pat_nxt = 1'b0;
        end else if (idx_r == ogg_pkg::HDR_VERSION) begin
          if (in_byte != 8'd0) pat_nxt = 1'b0;
        end else if (idx_r == ogg_pkg::HDR_TYPE) begin
          type_nxt = in_byte;
        end else if (idx_r < ogg_pkg::HDR_SERIAL) begin
          gran_nxt[{goff[2:0], 3'b000} +: 8] = in_byte;
        end else if (idx_r < ogg_pkg::HDR_SEQUENCE) begin
          serial_nxt[{soff[1:0], 3'b000} +: 8] = in_byte;
        end else if (idx_r < ogg_pkg::HDR_CHECKSUM) begin
          seq_nxt[{qoff[1:0], 3'b000} +: 8] = in_byte;
        end else if (idx_r < ogg_pkg::HDR_LAST) begin
          csum_nxt[{coff[1:0], 3'b000} +: 8] = in_byte;
        end else begin
        end

        // Last header byte: check, then open the segment table
        if (idx_r >= ogg_pkg::HDR_LAST) begin
          ltot_nxt  = in_byte;
          psum_nxt  = 17'd0;
          pleft_nxt = 17'd0;
          idx_nxt   = 5'd0;
          pat_nxt   = 1'b1;
          if (!pat_r) begin
            kind      = ogg_pkg::KIND_ERROR;
            lleft_nxt = 8'd0;
            phase_nxt = ogg_pkg::PH_HEADER;
          end else begin
            hvalid    = 1'b1;
            lleft_nxt = in_byte;
            if (in_byte == 8'd0) begin
              pend      = 1'b1;
              phase_nxt = ogg_pkg::PH_HEADER;
            end else begin
              phase_nxt = ogg_pkg::PH_LACING;
            end
          end
        end else begin
          phase_nxt = ogg_pkg::PH_HEADER;
          idx_nxt   = idx_r + 5'd1;
        end
      end
    endcase
  end

  // Result word reflects the held fields after this byte's update
  always_comb begin
    res.byte_kind        = kind;
    res.payload_data     = data;
    res.header_valid     = hvalid;
    res.page_flags       = type_nxt;
    res.granule_position = gran_nxt;
    res.stream_serial    = serial_nxt;
    res.page_sequence    = seq_nxt;
    res.page_checksum    = csum_nxt;
    res.lacing_count     = ltot_nxt;
    res.payload_size     = psum_nxt[15:0];
    res.page_end         = pend;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= ogg_pkg::PH_HEADER;
      idx_r    <= 5'd0;
      pat_r    <= 1'b1;
      type_r   <= 8'd0;
      gran_r   <= 64'd0;
      serial_r <= 32'd0;
      seq_r    <= 32'd0;
      csum_r   <= 32'd0;
      ltot_r   <= 8'd0;
      lleft_r  <= 8'd0;
      psum_r   <= 17'd0;
      pleft_r  <= 17'd0;
    end else if (fire) begin
      phase_r  <= phase_nxt;
      idx_r    <= idx_nxt;
      pat_r    <= pat_nxt;
      type_r   <= type_nxt;
      gran_r   <= gran_nxt;
      serial_r <= serial_nxt;
      seq_r    <= seq_nxt;
      csum_r   <= csum_nxt;
      ltot_r   <= ltot_nxt;
      lleft_r  <= lleft_nxt;
      psum_r   <= psum_nxt;
      pleft_r  <= pleft_nxt;
    end
  end

  // Checks
  a_valid_is_header: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.header_valid |-> res.byte_kind == ogg_pkg::KIND_HEADER)
    else $error("header_valid on a non-header word");

  a_error_no_end: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.byte_kind == ogg_pkg::KIND_ERROR |-> !res.page_end)
    else $error("page end flagged on a header error");

  a_payload_left: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == ogg_pkg::PH_PAYLOAD |-> pleft_r != 17'd0)
    else $error("payload phase with nothing left");

  a_lacing_left: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == ogg_pkg::PH_LACING |-> lleft_r != 8'd0)
    else $error("lacing phase with no lacing bytes left");

  a_end_restart: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.page_end |=> phase_r == ogg_pkg::PH_HEADER && idx_r == 5'd0)
    else $error("parser did not restart after page end");

endmodule

// ----- src/ogg_out_stage.sv -----
// ---------------------------------------------------------------------------
// ogg_out_stage: result register
// Holds one result word until the sink takes it; reloads in the same cycle.
// ---------------------------------------------------------------------------
module ogg_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  ogg_pkg::result_t res,
  output logic             can_load,
  ogg_out_if.source        out_ch
);

  logic             valid_r, valid_nxt;
  ogg_pkg::result_t res_r;

  // Room when empty or when the held word is taken this cycle
  assign can_load  = !valid_r || out_ch.ready;
  assign valid_nxt = fire ? 1'b1 : (out_ch.ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  // Drive the result channel
  assign out_ch.valid            = valid_r;
  assign out_ch.byte_kind        = res_r.byte_kind;
  assign out_ch.payload_data     = res_r.payload_data;
  assign out_ch.header_valid     = res_r.header_valid;
  assign out_ch.page_flags       = res_r.page_flags;
  assign out_ch.granule_position = res_r.granule_position;
  assign out_ch.stream_serial    = res_r.stream_serial;
  assign out_ch.page_sequence    = res_r.page_sequence;
  assign out_ch.page_checksum    = res_r.page_checksum;
  assign out_ch.lacing_count     = res_r.lacing_count;
  assign out_ch.payload_size     = res_r.payload_size;
  assign out_ch.page_end         = res_r.page_end;

endmodule

// ----- src/ogg_page_header_parser.sv -----
// A byte passes the input register, parse logic and result register in order.
// Throughput: one byte per clock while the result channel is ready.
// Ready falls only while both the input and result registers hold words.
// Reset (synchronous, rst_n low): expects header byte 0, held fields zero,
// both registers empty.
// ---------------------------------------------------------------------------
// ogg_page_header_parser: Ogg page header parser top level
// Tags each stream word as header, lacing, payload or error and reports page fields.
// ---------------------------------------------------------------------------
module ogg_page_header_parser (
  input  logic      clk,
  input  logic      rst_n,
  ogg_in_if.sink    in_ch,
  ogg_out_if.source out_ch
);

  logic             held_valid;
  logic [7:0]       held_byte;
  logic             can_load;
  logic             fire;
  ogg_pkg::result_t res;

  // A held byte is parsed when the result register has room
  assign fire = held_valid && can_load;

  ogg_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .take       (fire),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  ogg_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .in_byte (held_byte),
    .res     (res)
  );

  ogg_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .res      (res),
    .can_load (can_load),
    .out_ch   (out_ch)
  );

endmodule

// ----- tb/testbench.sv -----
// ---------------------------------------------------------------------------
// testbench: self-checking bench for the Ogg page header parser
// Streams Ogg pages (clean, corrupted and junk) into the parser and checks
// every tagged result word against a cycle-free model of the page parse.
// ---------------------------------------------------------------------------
module testbench;

  localparam logic [31:0] SYNC_WORD    = "OggS";
  localparam int          HDR_BYTES    = 27;
  localparam int          STREAM_BYTES = 1450;
  localparam int          NO_FAULT     = -1;
  localparam int          RUN_LIMIT    = 1000000;
  localparam int          MAX_SHOWN    = 10;

  typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

  logic clk = 1'b0;
  logic rst_n;

  ogg_in_if  in_ch ();
  ogg_out_if out_ch ();

  ogg_page_header_parser dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Stream to send, expected result words, drain points (byte counts)
  logic [7:0]       byte_queue [$];
  ogg_pkg::result_t parse_expect [$];
  int               drain_marks [$];

  int bytes_taken = 0;
  int total_bytes = 1;
  int stage = 0;
  int fails = 0;
  int words_seen = 0;

  // Parser model state
  ogg_pkg::phase_t cur_phase;
  logic [4:0]      hdr_pos;
  bit              sync_ok;
  logic [7:0]      h_type;
  logic [63:0]     h_gran;
  logic [31:0]     h_serial;
  logic [31:0]     h_seq;
  logic [31:0]     h_crc;
  logic [7:0]      h_count;
  logic [7:0]      lace_remaining;
  logic [16:0]     size_acc;
  logic [16:0]     bytes_remaining;

  function automatic void restart_header();
    cur_phase = ogg_pkg::PH_HEADER;
    hdr_pos   = '0;
    sync_ok   = 1'b1;
  endfunction

  // Advance the page parse by one byte and return the word it produces
  function automatic ogg_pkg::result_t parse_byte(input logic [7:0] b);
    ogg_pkg::result_t r;
    r = '0;
    r.byte_kind = ogg_pkg::KIND_HEADER;
    case (cur_phase)
      ogg_pkg::PH_LACING: begin
        r.byte_kind = ogg_pkg::KIND_LACING;
        size_acc = size_acc + 17'(b);
        lace_remaining = lace_remaining - 8'd1;
        if (lace_remaining == 8'd0) begin
          if (size_acc == '0) begin
            r.page_end = 1'b1;
            restart_header();
          end else begin
            bytes_remaining = size_acc;
            cur_phase = ogg_pkg::PH_PAYLOAD;
          end
        end
      end
      ogg_pkg::PH_PAYLOAD: begin
        r.byte_kind = ogg_pkg::KIND_PAYLOAD;
        r.payload_data = b;
        bytes_remaining = bytes_remaining - 17'd1;
        if (bytes_remaining == '0) begin
          r.page_end = 1'b1;
          restart_header();
        end
      end
      default: begin
        // collect header fields, little-endian
        if (hdr_pos < ogg_pkg::HDR_VERSION) begin
          if (b != SYNC_WORD[31 - 8 * hdr_pos -: 8]) sync_ok = 1'b0;
        end else if (hdr_pos == ogg_pkg::HDR_VERSION) begin
          if (b != 8'h00) sync_ok = 1'b0;
        end else if (hdr_pos == ogg_pkg::HDR_TYPE) begin
          h_type = b;
        end else if (hdr_pos < ogg_pkg::HDR_SERIAL) begin
          h_gran[(hdr_pos - ogg_pkg::HDR_GRANULE) * 8 +: 8] = b;
        end else if (hdr_pos < ogg_pkg::HDR_SEQUENCE) begin
          h_serial[(hdr_pos - ogg_pkg::HDR_SERIAL) * 8 +: 8] = b;
        end else if (hdr_pos < ogg_pkg::HDR_CHECKSUM) begin
          h_seq[(hdr_pos - ogg_pkg::HDR_SEQUENCE) * 8 +: 8] = b;
        end else if (hdr_pos < ogg_pkg::HDR_LAST) begin
          h_crc[(hdr_pos - ogg_pkg::HDR_CHECKSUM) * 8 +: 8] = b;
        end

        if (hdr_pos >= ogg_pkg::HDR_LAST) begin
          h_count = b;
          size_acc = '0;
          bytes_remaining = '0;
          if (!sync_ok) begin
            r.byte_kind = ogg_pkg::KIND_ERROR;
            lace_remaining = 8'd0;
            restart_header();
          end else begin
            r.header_valid = 1'b1;
            lace_remaining = b;
            if (b == 8'd0) begin
              r.page_end = 1'b1;
              restart_header();
            end else begin
              restart_header();
              cur_phase = ogg_pkg::PH_LACING;
            end
          end
        end else begin
          hdr_pos = hdr_pos + 5'd1;
        end
      end
    endcase
    r.page_flags       = h_type;
    r.granule_position = h_gran;
    r.stream_serial    = h_serial;
    r.page_sequence    = h_seq;
    r.page_checksum    = h_crc;
    r.lacing_count     = h_count;
    r.payload_size     = size_acc[15:0];
    return r;
  endfunction

  // Queue one page: header, then lacing and payload unless corrupted
  task automatic add_page(input int lace_n, input int lace_lo, input int lace_hi,
                          input fill_t fill, input int bad_pos);
    logic [7:0] hdr [HDR_BYTES];
    logic [7:0] lace;
    int i;
    int body;
    body = 0;
    for (i = 0; i < HDR_BYTES; i++) begin
      case (fill)
        FILL_ZERO: hdr[i] = 8'h00;
        FILL_ONES: hdr[i] = 8'hFF;
        default:   hdr[i] = 8'($urandom);
      endcase
    end
    for (i = 0; i < 4; i++) hdr[i] = SYNC_WORD[31 - 8 * i -: 8];
    hdr[ogg_pkg::HDR_VERSION] = 8'h00;
    hdr[ogg_pkg::HDR_LAST] = 8'(lace_n);
    if (bad_pos != NO_FAULT) hdr[bad_pos] = hdr[bad_pos] ^ 8'($urandom_range(255, 1));
    for (i = 0; i < HDR_BYTES; i++) byte_queue.push_back(hdr[i]);
    if (bad_pos != NO_FAULT) return;
    for (i = 0; i < lace_n; i++) begin
      lace = 8'($urandom_range(lace_hi, lace_lo));
      body += lace;
      byte_queue.push_back(lace);
    end
    for (i = 0; i < body; i++) byte_queue.push_back(8'($urandom));
  endtask

  function automatic int send_gap_pct(input int st);
    return (st == 0) ? 24 : (st == 1) ? 46 : 0;
  endfunction

  function automatic int recv_gap_pct(input int st);
    return (st == 0) ? 46 : (st == 1) ? 24 : 0;
  endfunction

  // Compare the word on the result channel with the oldest expectation
  task automatic check_word(input ogg_pkg::result_t want);
    ogg_pkg::result_t got;
    string            diffs;
    got.byte_kind        = ogg_pkg::kind_t'(out_ch.byte_kind);
    got.payload_data     = out_ch.payload_data;
    got.header_valid     = out_ch.header_valid;
    got.page_flags       = out_ch.page_flags;
    got.granule_position = out_ch.granule_position;
    got.stream_serial    = out_ch.stream_serial;
    got.page_sequence    = out_ch.page_sequence;
    got.page_checksum    = out_ch.page_checksum;
    got.lacing_count     = out_ch.lacing_count;
    got.payload_size     = out_ch.payload_size;
    got.page_end         = out_ch.page_end;
    diffs = "";
    if (got.byte_kind !== want.byte_kind)
      diffs = {diffs, $sformatf(" kind %0d/%0d", want.byte_kind, got.byte_kind)};
    if (got.payload_data !== want.payload_data)
      diffs = {diffs, $sformatf(" data %h/%h", want.payload_data, got.payload_data)};
    if (got.header_valid !== want.header_valid)
      diffs = {diffs, $sformatf(" hvalid %b/%b", want.header_valid, got.header_valid)};
    if (got.page_flags !== want.page_flags)
      diffs = {diffs, $sformatf(" flags %h/%h", want.page_flags, got.page_flags)};
    if (got.granule_position !== want.granule_position)
      diffs = {diffs, $sformatf(" granule %h/%h", want.granule_position,
                                got.granule_position)};
    if (got.stream_serial !== want.stream_serial)
      diffs = {diffs, $sformatf(" serial %h/%h", want.stream_serial, got.stream_serial)};
    if (got.page_sequence !== want.page_sequence)
      diffs = {diffs, $sformatf(" seq %h/%h", want.page_sequence, got.page_sequence)};
    if (got.page_checksum !== want.page_checksum)
      diffs = {diffs, $sformatf(" crc %h/%h", want.page_checksum, got.page_checksum)};
    if (got.lacing_count !== want.lacing_count)
      diffs = {diffs, $sformatf(" lacing %h/%h", want.lacing_count, got.lacing_count)};
    if (got.payload_size !== want.payload_size)
      diffs = {diffs, $sformatf(" size %h/%h", want.payload_size, got.payload_size)};
    if (got.page_end !== want.page_end)
      diffs = {diffs, $sformatf(" end %b/%b", want.page_end, got.page_end)};
    if (diffs != "") begin
      fails++;
      if (fails <= MAX_SHOWN)
        $display("mismatch on word %0d (expected/actual):%s", words_seen, diffs);
    end
  endtask

  // Driver: present the next byte, stall at random, hold at drain points
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid       <= 1'b0;
      in_ch.stream_byte <= 8'h00;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        parse_expect.push_back(parse_byte(in_ch.stream_byte));
        bytes_taken++;
        stage = (bytes_taken * 3) / total_bytes;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (drain_marks.size() != 0 && bytes_taken == drain_marks[0] &&
            parse_expect.size() == 0)
          drain_marks.pop_front();
        if (byte_queue.size() != 0 &&
            !(drain_marks.size() != 0 && bytes_taken == drain_marks[0]) &&
            $urandom_range(99) >= send_gap_pct(stage)) begin
          in_ch.valid       <= 1'b1;
          in_ch.stream_byte <= byte_queue.pop_front();
        end else begin
          in_ch.valid       <= 1'b0;
          in_ch.stream_byte <= 8'($urandom);
        end
      end
    end
  end

  // Monitor: check accepted words, toggle ready at random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (parse_expect.size() == 0) begin
          fails++;
          if (fails <= MAX_SHOWN)
            $display("unexpected word %0d: kind %0d", words_seen, out_ch.byte_kind);
        end else begin
          check_word(parse_expect.pop_front());
        end
        words_seen++;
      end
      out_ch.ready <= ($urandom_range(99) >= recv_gap_pct(stage));
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int directed_end;
    int pick;
    int lace_n;
    int k;
    bit mid_marked;
    rst_n      = 1'b0;
    mid_marked = 1'b0;

    restart_header();
    h_type          = '0;
    h_gran          = '0;
    h_serial        = '0;
    h_seq           = '0;
    h_crc           = '0;
    h_count         = '0;
    lace_remaining  = '0;
    size_acc        = '0;
    bytes_remaining = '0;

    // directed: empty page, all-zero lacing, max lacing value, bad headers
    add_page(0, 0, 0, FILL_ZERO, NO_FAULT);
    add_page(2, 0, 0, FILL_ONES, NO_FAULT);
    add_page(1, 255, 255, FILL_RANDOM, NO_FAULT);
    add_page(3, 1, 6, FILL_RANDOM, NO_FAULT);
    for (k = 0; k <= int'(ogg_pkg::HDR_VERSION); k++)
      add_page((k == 0) ? 0 : 255, 0, 0, FILL_RANDOM, k);
    add_page(255, 0, 0, FILL_RANDOM, NO_FAULT);
    add_page(1, 1, 1, FILL_ONES, NO_FAULT);
    directed_end = byte_queue.size();
    drain_marks.push_back(directed_end);

    // random: mostly clean pages, some corrupted headers and junk headers
    while (byte_queue.size() < STREAM_BYTES) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        repeat (HDR_BYTES) byte_queue.push_back(8'($urandom));
      end else if (pick < 20) begin
        add_page($urandom_range(255, 0), 0, 0, FILL_RANDOM,
                 $urandom_range(int'(ogg_pkg::HDR_VERSION), 0));
      end else begin
        lace_n = (pick < 26) ? $urandom_range(40, 7) : $urandom_range(6, 0);
        if (pick >= 92 && lace_n <= 2)
          add_page(lace_n, 0, 255, FILL_RANDOM, NO_FAULT);
        else if (pick >= 86)
          add_page(lace_n, 0, 0, FILL_RANDOM, NO_FAULT);
        else
          add_page(lace_n, 0, 12, FILL_RANDOM, NO_FAULT);
      end
      if (!mid_marked && byte_queue.size() > (directed_end + STREAM_BYTES) / 2) begin
        drain_marks.push_back(byte_queue.size());
        mid_marked = 1'b1;
      end
    end
    total_bytes = byte_queue.size();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (byte_queue.size() != 0 || in_ch.valid) @(posedge clk);
    while (parse_expect.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (fails == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

  // Watchdog
  initial begin
    #RUN_LIMIT;
    $display("testbench: FAIL");
    $finish;
  end

endmodule
